### rtl/afrc_pkg.sv
// Shared types, constants and sample conversion for the audio format rate converter.
`default_nettype none

package afrc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int RATE_W     = 22;
    localparam int MAX_RUN    = 64;
    localparam int RUN_W      = 7;
    localparam int REG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;

    // Input sample encodings
    typedef enum logic [1:0] {
        FMT_U8  = 2'd0,
        FMT_S8  = 2'd1,
        FMT_U16 = 2'd2,
        FMT_S16 = 2'd3
    } sample_format_t;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_STEREO_MODE   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RATE_STEP     = 2'd2;

    // Reset values: signed 16-bit stereo, unity rate
    localparam sample_format_t     FORMAT_RESET    = FMT_S16;
    localparam logic               STEREO_RESET    = 1'b1;
    localparam logic [RATE_W-1:0]  RATE_STEP_RESET = 22'd65536;

    typedef struct packed {
        sample_format_t      sample_format;
        logic                stereo_mode;
        logic [RATE_W-1:0]   rate_step;
    } cfg_t;

    // Convert one raw sample to signed 16-bit; unsigned formats flip the sign bit
    function automatic logic signed [SAMPLE_W-1:0] to_s16(
        input logic [SAMPLE_W-1:0] raw,
        input sample_format_t      fmt
    );
        logic signed [SAMPLE_W-1:0] res;
        unique case (fmt)
            FMT_U8:  res = {raw[7] ^ 1'b1, raw[6:0], 8'h00};
            FMT_S8:  res = {raw[7:0], 8'h00};
            FMT_U16: res = {raw[15] ^ 1'b1, raw[14:0]};
            FMT_S16: res = raw;
            default: res = raw;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/afrc_job_fifo.sv
// Two-entry queue carrying averaging jobs from the front end to the divider.
`default_nettype none

module afrc_job_fifo #(
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      pop_data,
    output logic                   empty
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Store incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/afrc_front.sv
// Front end: converts samples, accumulates sums, advances the phase and issues jobs.
`default_nettype none

module afrc_front #(
    parameter int PHASE_FRAC_BITS = 16,
    parameter int COUNT_WIDTH     = 17
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire afrc_pkg::cfg_t                    cfg,
    input  wire logic                              push,
    input  wire logic [afrc_pkg::SAMPLE_W-1:0]     left_raw,
    input  wire logic [afrc_pkg::SAMPLE_W-1:0]     right_raw,
    output logic                                   full,
    input  wire logic                              job_full,
    output logic                                   job_push,
    output logic signed [COUNT_WIDTH+15:0]         job_left_sum,
    output logic signed [COUNT_WIDTH+15:0]         job_right_sum,
    output logic [COUNT_WIDTH-1:0]                 job_count,
    output logic [afrc_pkg::RUN_W-1:0]             job_runs,
    output logic                                   job_stereo
);
    import afrc_pkg::*;

    localparam int SUM_W = COUNT_WIDTH + SAMPLE_W;
    localparam int TOT_W = ((PHASE_FRAC_BITS > RATE_W) ? PHASE_FRAC_BITS : RATE_W) + 1;
    localparam int CAR_W = TOT_W - PHASE_FRAC_BITS;

    logic [PHASE_FRAC_BITS-1:0] phase_reg;
    logic signed [SUM_W-1:0]    left_sum_reg;
    logic signed [SUM_W-1:0]    right_sum_reg;
    logic [COUNT_WIDTH-1:0]     count_reg;

    logic signed [SAMPLE_W-1:0] left_s16;
    logic signed [SAMPLE_W-1:0] right_s16;
    logic signed [SUM_W-1:0]    left_sum_next;
    logic signed [SUM_W-1:0]    right_sum_next;
    logic [COUNT_WIDTH-1:0]     count_next;
    logic                       count_sat;
    logic [TOT_W-1:0]           total;
    logic [CAR_W-1:0]           carries;
    logic [RUN_W-1:0]           runs;
    logic                       accept;
    logic                       emit;

    // Accept only while the job queue has room
    assign full   = job_full;
    assign accept = push && !full;

    // Convert and accumulate, holding once the count saturates
    always_comb
    begin
        left_s16       = to_s16(left_raw, cfg.sample_format);
        right_s16      = to_s16(right_raw, cfg.sample_format);
        count_sat      = &count_reg;
        left_sum_next  = left_sum_reg;
        right_sum_next = right_sum_reg;
        count_next     = count_reg;
        if (!count_sat)
        begin
            left_sum_next = left_sum_reg
                + {{(SUM_W-SAMPLE_W){left_s16[SAMPLE_W-1]}}, left_s16};
            if (cfg.stereo_mode)
            begin
                right_sum_next = right_sum_reg
                    + {{(SUM_W-SAMPLE_W){right_s16[SAMPLE_W-1]}}, right_s16};
            end
            count_next = count_reg + 1'b1;
        end
    end

    // Advance phase and clamp the number of whole carries
    always_comb
    begin
        total   = TOT_W'(phase_reg) + TOT_W'(cfg.rate_step);
        carries = total[TOT_W-1:PHASE_FRAC_BITS];
        if (32'(carries) > 32'(MAX_RUN))
        begin
            runs = RUN_W'(MAX_RUN);
        end
        else
        begin
            runs = RUN_W'(carries);
        end
        emit = (runs != '0);
    end

    assign job_push      = accept && emit;
    assign job_left_sum  = left_sum_next;
    assign job_right_sum = right_sum_next;
    assign job_count     = count_next;
    assign job_runs      = runs;
    assign job_stereo    = cfg.stereo_mode;

    // Update running state; clear sums whenever a job leaves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            left_sum_reg  <= '0;
            right_sum_reg <= '0;
            count_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg <= total[PHASE_FRAC_BITS-1:0];
            if (emit)
            begin
                left_sum_reg  <= '0;
                right_sum_reg <= '0;
                count_reg     <= '0;
            end
            else
            begin
                left_sum_reg  <= left_sum_next;
                right_sum_reg <= right_sum_next;
                count_reg     <= count_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/afrc_back.sv
// Back end: divides sums by the frame count and emits the averaged pair run.
`default_nettype none

module afrc_back #(
    parameter int COUNT_WIDTH = 17
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              job_empty,
    output logic                                   job_pop,
    input  wire logic signed [COUNT_WIDTH+15:0]    job_left_sum,
    input  wire logic signed [COUNT_WIDTH+15:0]    job_right_sum,
    input  wire logic [COUNT_WIDTH-1:0]            job_count,
    input  wire logic [afrc_pkg::RUN_W-1:0]        job_runs,
    input  wire logic                              job_stereo,
    input  wire logic                              pop,
    output logic                                   empty,
    output logic signed [afrc_pkg::SAMPLE_W-1:0]   left_out,
    output logic signed [afrc_pkg::SAMPLE_W-1:0]   right_out,
    output logic                                   last_of_run
);
    import afrc_pkg::*;

    localparam int SUM_W = COUNT_WIDTH + SAMPLE_W;
    localparam int CNT_W = $clog2(SUM_W + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [SUM_W-1:0]        l_quo_reg;
    logic [SUM_W-1:0]        r_quo_reg;
    logic [COUNT_WIDTH-1:0]  l_rem_reg;
    logic [COUNT_WIDTH-1:0]  r_rem_reg;
    logic                    l_neg_reg;
    logic                    r_neg_reg;
    logic [COUNT_WIDTH-1:0]  div_reg;
    logic [CNT_W-1:0]        bit_cnt_reg;
    logic [RUN_W-1:0]        runs_reg;
    logic                    stereo_reg;
    logic [SAMPLE_W-1:0]     l_avg_reg;
    logic [SAMPLE_W-1:0]     r_avg_reg;
    logic                    out_valid_reg;
    logic [SAMPLE_W-1:0]     left_out_reg;
    logic [SAMPLE_W-1:0]     right_out_reg;
    logic                    last_reg;

    logic [COUNT_WIDTH:0]    l_trial;
    logic [COUNT_WIDTH:0]    r_trial;
    logic                    l_ge;
    logic                    r_ge;
    logic [COUNT_WIDTH:0]    l_diff;
    logic [COUNT_WIDTH:0]    r_diff;
    logic [SUM_W-1:0]        l_quo_next;
    logic [SUM_W-1:0]        r_quo_next;
    logic [SUM_W-1:0]        l_signed_q;
    logic [SUM_W-1:0]        r_signed_q;
    logic                    slot_free;

    assign job_pop     = (state_reg == ST_IDLE) && !job_empty;
    assign slot_free   = !out_valid_reg || pop;
    assign empty       = !out_valid_reg;
    assign left_out    = left_out_reg;
    assign right_out   = right_out_reg;
    assign last_of_run = last_reg;

    // One restoring division step on both channels
    always_comb
    begin
        l_trial    = {l_rem_reg, l_quo_reg[SUM_W-1]};
        r_trial    = {r_rem_reg, r_quo_reg[SUM_W-1]};
        l_ge       = (l_trial >= {1'b0, div_reg});
        r_ge       = (r_trial >= {1'b0, div_reg});
        l_diff     = l_trial - {1'b0, div_reg};
        r_diff     = r_trial - {1'b0, div_reg};
        l_quo_next = {l_quo_reg[SUM_W-2:0], l_ge};
        r_quo_next = {r_quo_reg[SUM_W-2:0], r_ge};
        l_signed_q = l_neg_reg ? (SUM_W'(0) - l_quo_next) : l_quo_next;
        r_signed_q = r_neg_reg ? (SUM_W'(0) - r_quo_next) : r_quo_next;
    end

    // Sequence: take a job, divide, then emit the run of pairs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            l_quo_reg     <= '0;
            r_quo_reg     <= '0;
            l_rem_reg     <= '0;
            r_rem_reg     <= '0;
            l_neg_reg     <= 1'b0;
            r_neg_reg     <= 1'b0;
            div_reg       <= '0;
            bit_cnt_reg   <= '0;
            runs_reg      <= '0;
            stereo_reg    <= 1'b0;
            l_avg_reg     <= '0;
            r_avg_reg     <= '0;
            out_valid_reg <= 1'b0;
            left_out_reg  <= '0;
            right_out_reg <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            // Drop the output word once taken unless the emit state refills it
            if (pop && out_valid_reg && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!job_empty)
                    begin
                        l_neg_reg   <= job_left_sum[SUM_W-1];
                        r_neg_reg   <= job_right_sum[SUM_W-1];
                        l_quo_reg   <= job_left_sum[SUM_W-1]
                                       ? (SUM_W'(0) - job_left_sum) : job_left_sum;
                        r_quo_reg   <= job_right_sum[SUM_W-1]
                                       ? (SUM_W'(0) - job_right_sum) : job_right_sum;
                        l_rem_reg   <= '0;
                        r_rem_reg   <= '0;
                        div_reg     <= (job_count == '0) ? COUNT_WIDTH'(1) : job_count;
                        bit_cnt_reg <= CNT_W'(SUM_W);
                        runs_reg    <= job_runs;
                        stereo_reg  <= job_stereo;
                        state_reg   <= ST_DIVIDE;
                    end
                end

                ST_DIVIDE:
                begin
                    l_quo_reg   <= l_quo_next;
                    r_quo_reg   <= r_quo_next;
                    l_rem_reg   <= l_ge ? l_diff[COUNT_WIDTH-1:0] : l_trial[COUNT_WIDTH-1:0];
                    r_rem_reg   <= r_ge ? r_diff[COUNT_WIDTH-1:0] : r_trial[COUNT_WIDTH-1:0];
                    bit_cnt_reg <= bit_cnt_reg - 1'b1;
                    if (bit_cnt_reg == CNT_W'(1))
                    begin
                        l_avg_reg <= l_signed_q[SAMPLE_W-1:0];
                        r_avg_reg <= stereo_reg ? r_signed_q[SAMPLE_W-1:0]
                                                : l_signed_q[SAMPLE_W-1:0];
                        state_reg <= ST_EMIT;
                    end
                end

                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        left_out_reg  <= l_avg_reg;
                        right_out_reg <= r_avg_reg;
                        last_reg      <= (runs_reg == RUN_W'(1));
                        runs_reg      <= runs_reg - 1'b1;
                        if (runs_reg == RUN_W'(1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/audio_format_rate_converter.sv
// Top level of the audio format rate converter: config registers, front end, job queue, back end.
`default_nettype none

// Box-average fractional resampler. Each pushed frame is converted to signed
// 16-bit (U8/S8 shifted left 8, unsigned formats offset by half scale), added
// into running left/right sums and counted, and advances a phase accumulator
// with PHASE_FRAC_BITS fraction bits by rate_step. Every whole carry of the
// phase emits one pair equal to sum / count, truncated toward zero; a frame
// carrying more than 64 units emits 64. A frame that emits nothing only
// updates the sums, count and phase. A frame that emits hands a job to a
// two-entry queue; the back end divides both sums with a bit-serial restoring
// divider, one quotient bit per cycle, then drives one pair per cycle while
// pop keeps up. The front end keeps accepting frames until the queue holds
// two pending jobs. Write configuration only while the block is idle.
module audio_format_rate_converter #(
    parameter int PHASE_FRAC_BITS = 16,
    parameter int COUNT_WIDTH     = 17
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [afrc_pkg::REG_IDX_W-1:0]      cfg_index,
    input  wire logic [afrc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [afrc_pkg::SAMPLE_W-1:0]       left_raw,
    input  wire logic [afrc_pkg::SAMPLE_W-1:0]       right_raw,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic signed [afrc_pkg::SAMPLE_W-1:0]     left_out,
    output logic signed [afrc_pkg::SAMPLE_W-1:0]     right_out,
    output logic                                     last_of_run
);
    import afrc_pkg::*;

    localparam int SUM_W  = COUNT_WIDTH + SAMPLE_W;
    localparam int JOB_W  = 2 * SUM_W + COUNT_WIDTH + RUN_W + 1;

    cfg_t                       cfg_reg;
    logic                       job_full;
    logic                       job_empty;
    logic                       job_push;
    logic                       job_pop;
    logic [JOB_W-1:0]           job_in;
    logic [JOB_W-1:0]           job_out;
    logic signed [SUM_W-1:0]    f_left_sum;
    logic signed [SUM_W-1:0]    f_right_sum;
    logic [COUNT_WIDTH-1:0]     f_count;
    logic [RUN_W-1:0]           f_runs;
    logic                       f_stereo;
    logic signed [SUM_W-1:0]    b_left_sum;
    logic signed [SUM_W-1:0]    b_right_sum;
    logic [COUNT_WIDTH-1:0]     b_count;
    logic [RUN_W-1:0]           b_runs;
    logic                       b_stereo;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_format <= FORMAT_RESET;
            cfg_reg.stereo_mode   <= STEREO_RESET;
            cfg_reg.rate_step     <= RATE_STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SAMPLE_FORMAT: cfg_reg.sample_format <= sample_format_t'(cfg_data[1:0]);
                REG_STEREO_MODE:   cfg_reg.stereo_mode   <= cfg_data[0];
                REG_RATE_STEP:     cfg_reg.rate_step     <= cfg_data[RATE_W-1:0];
                default:           ;
            endcase
        end
    end

    afrc_front #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
        .COUNT_WIDTH     (COUNT_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .push          (push),
        .left_raw      (left_raw),
        .right_raw     (right_raw),
        .full          (full),
        .job_full      (job_full),
        .job_push      (job_push),
        .job_left_sum  (f_left_sum),
        .job_right_sum (f_right_sum),
        .job_count     (f_count),
        .job_runs      (f_runs),
        .job_stereo    (f_stereo)
    );

    // Pack and unpack the job word
    assign job_in = {f_left_sum, f_right_sum, f_count, f_runs, f_stereo};
    assign {b_left_sum, b_right_sum, b_count, b_runs, b_stereo} = job_out;

    afrc_job_fifo #(
        .DATA_W (JOB_W)
    ) u_job_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .pop_data  (job_out),
        .empty     (job_empty)
    );

    afrc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_empty     (job_empty),
        .job_pop       (job_pop),
        .job_left_sum  (b_left_sum),
        .job_right_sum (b_right_sum),
        .job_count     (b_count),
        .job_runs      (b_runs),
        .job_stereo    (b_stereo),
        .pop           (pop),
        .empty         (empty),
        .left_out      (left_out),
        .right_out     (right_out),
        .last_of_run   (last_of_run)
    );

endmodule

`default_nettype wire
